### rtl/core/fts_pkg.sv
// Shared types and constants for the FIFO thread scheduler with timed sleep.
package fts_pkg;

  localparam int MAX_THREADS_DEF = 16;
  localparam int TID_W           = 4;
  localparam int MS_W            = 20;
  localparam int TPS_W           = 14;
  localparam int TICK_W          = 32;
  localparam int WOKEN_W         = 5;
  localparam int PROD_W          = MS_W + TPS_W;
  localparam int MS_PER_SEC      = 1000;
  localparam int MUL_W           = 32;
  // Division by 1000 is a shift by 3 and then a multiply by the reciprocal of 125.
  localparam int DIV_SHIFT       = 3;
  localparam int RECIP_SHIFT     = 38;
  localparam logic [MUL_W-1:0] RECIP_125 = 32'd2199023256;
  localparam logic [TPS_W-1:0] TPS_RESET = 14'd100;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_SLEEP = 2'd2,
    CMD_SCHED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_DUP   = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN_RD,
    ST_SCAN_WK,
    ST_SCAN_CMP,
    ST_POP_RD,
    ST_POP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [TID_W-1:0] thread_id;
    logic [MS_W-1:0]  sleep_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TID_W-1:0]   next_thread;
    logic [WOKEN_W-1:0] woken_count;
  } out_item_t;

endpackage

### rtl/core/fts_ms_to_ticks.sv
// Millisecond to tick converter: one shared multiplier, used for the product and the divide.
module fts_ms_to_ticks (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fts_pkg::MS_W-1:0]     ms_i,
  input  logic [fts_pkg::TPS_W-1:0]    tps_i,
  output logic                         done_o,
  output logic [fts_pkg::TICK_W-1:0]   ticks_o
);

  localparam int PW = fts_pkg::PROD_W;
  localparam int MW = fts_pkg::MUL_W;

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [2*MW-1:0]            acc_q, acc_d;
  logic [MW-1:0]              mul_a;
  logic [MW-1:0]              mul_b;
  logic [2*MW-1:0]            mul_p;
  logic [fts_pkg::TICK_W-1:0] quot;

  // First pass forms ms times rate; second pass multiplies that product over 8 by the
  // reciprocal of 125, which is exact for every product below 2^34.
  assign mul_p = (2*MW)'(mul_a) * (2*MW)'(mul_b);

  always_comb begin
    busy_d = 1'b0;
    done_d = 1'b0;
    acc_d  = acc_q;
    mul_a  = MW'(ms_i);
    mul_b  = MW'(tps_i);
    if (busy_q) begin
      mul_a  = MW'(acc_q[PW-1:fts_pkg::DIV_SHIFT]);
      mul_b  = fts_pkg::RECIP_125;
      acc_d  = mul_p;
      done_d = 1'b1;
    end else if (start_i) begin
      acc_d  = mul_p;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // The quotient stays below 2^25, so the top product bits hold all of it.
  assign quot    = fts_pkg::TICK_W'(acc_q[2*MW-1:fts_pkg::RECIP_SHIFT]);
  assign done_o  = done_q;
  assign ticks_o = (quot == '0) ? fts_pkg::TICK_W'(1) : quot;

endmodule

### rtl/core/fifo_thread_scheduler_timed_sleep.sv
// Top level of the FIFO thread scheduler with timed sleep.
// Steps per item: tick and make-runnable go straight to the result; sleep forms the product,
// does the reciprocal multiply and stores the wake time; schedule reads, fetches and compares
// each sleep-list entry in turn, then reads the run queue head and pops a thread if any.
// One item is in work at a time; a result waits in the output register while the next
// item is accepted. Reset clears the counters, flags and tick count.
module fifo_thread_scheduler_timed_sleep #(
  parameter int MAX_THREADS = fts_pkg::MAX_THREADS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fts_pkg::TPS_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fts_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fts_pkg::out_item_t          out_data_o
);

  localparam int IDXW = $clog2(MAX_THREADS);
  localparam int CNTW = $clog2(MAX_THREADS + 1);
  localparam int TW   = fts_pkg::TICK_W;

  // Control state.
  fts_pkg::state_e           state_q, state_d;
  logic [fts_pkg::TPS_W-1:0] tps_q;
  logic [TW-1:0]             tick_q, tick_d;
  logic [CNTW-1:0]           run_cnt_q, run_cnt_d;
  logic [CNTW-1:0]           sleep_cnt_q, sleep_cnt_d;
  logic [IDXW-1:0]           head_q, head_d;
  logic [MAX_THREADS-1:0]    on_run_q, on_run_d;
  logic [MAX_THREADS-1:0]    sleeping_q, sleeping_d;
  logic [CNTW-1:0]           scan_i_q, scan_i_d;
  logic [CNTW-1:0]           kept_q, kept_d;
  logic [CNTW-1:0]           woken_q, woken_d;
  logic                      out_valid_q, out_valid_d;

  // Payload registers.
  logic [IDXW-1:0]           cur_id_q, cur_id_d;
  fts_pkg::out_item_t        res_q, res_d;
  fts_pkg::out_item_t        out_q, out_d;

  // Memories: run queue ring, sleep list and per-thread wake times.
  logic [IDXW-1:0] run_mem   [MAX_THREADS];
  logic [IDXW-1:0] order_mem [MAX_THREADS];
  logic [TW-1:0]   wake_mem  [MAX_THREADS];
  logic [IDXW-1:0] run_rd_q;
  logic [IDXW-1:0] order_rd_q;
  logic [TW-1:0]   wake_rd_q;

  logic            run_we;
  logic [IDXW-1:0] run_wa;
  logic [IDXW-1:0] run_wd;
  logic            order_we;
  logic [IDXW-1:0] order_wa;
  logic [IDXW-1:0] order_wd;
  logic            wake_we;
  logic [TW-1:0]   wake_wd;

  // Converter handshake.
  logic            conv_start;
  logic            conv_done;
  logic [TW-1:0]   conv_ticks;

  logic            in_fire;
  logic            id_ok;
  logic [IDXW-1:0] in_idx;
  logic [CNTW:0]   tail_sum;
  logic [IDXW-1:0] tail_idx;
  logic [IDXW-1:0] head_inc;
  logic            due;

  fts_ms_to_ticks u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .ms_i    (in_data_i.sleep_ms),
    .tps_i   (tps_q),
    .done_o  (conv_done),
    .ticks_o (conv_ticks)
  );

  assign in_ready_o = (state_q == fts_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Thread ids at or above the thread count are ignored with an ok status.
  assign id_ok  = ({{(32-fts_pkg::TID_W){1'b0}}, in_data_i.thread_id} < MAX_THREADS);
  assign in_idx = IDXW'(in_data_i.thread_id);

  // The run queue is a ring: the tail is the head plus the count, wrapped once.
  assign tail_sum = (CNTW+1)'(head_q) + (CNTW+1)'(run_cnt_q);
  assign tail_idx = (tail_sum >= (CNTW+1)'(MAX_THREADS)) ?
                    IDXW'(tail_sum - (CNTW+1)'(MAX_THREADS)) : IDXW'(tail_sum);
  assign head_inc = (head_q == IDXW'(MAX_THREADS - 1)) ? '0 : head_q + IDXW'(1);

  // The wake test is a plain unsigned compare against the current tick.
  assign due = (tick_q >= wake_rd_q);

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    run_cnt_d   = run_cnt_q;
    sleep_cnt_d = sleep_cnt_q;
    head_d      = head_q;
    on_run_d    = on_run_q;
    sleeping_d  = sleeping_q;
    scan_i_d    = scan_i_q;
    kept_d      = kept_q;
    woken_d     = woken_q;
    cur_id_d    = cur_id_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    run_we      = 1'b0;
    run_wa      = tail_idx;
    run_wd      = in_idx;
    order_we    = 1'b0;
    order_wa    = IDXW'(sleep_cnt_q);
    order_wd    = cur_id_q;
    wake_we     = 1'b0;
    wake_wd     = tick_q + conv_ticks;
    conv_start  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      fts_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_d.status      = fts_pkg::STAT_OK;
          res_d.next_thread = '0;
          res_d.woken_count = '0;
          cur_id_d          = in_idx;
          state_d           = fts_pkg::ST_DONE;
          case (fts_pkg::cmd_e'(in_data_i.command))
            fts_pkg::CMD_TICK: begin
              tick_d = tick_q + TW'(1);
            end
            fts_pkg::CMD_RUN: begin
              if (id_ok) begin
                if (on_run_q[in_idx]) begin
                  res_d.status = fts_pkg::STAT_DUP;
                end else if (run_cnt_q < CNTW'(MAX_THREADS)) begin
                  run_we           = 1'b1;
                  run_cnt_d        = run_cnt_q + CNTW'(1);
                  on_run_d[in_idx] = 1'b1;
                end
              end
            end
            fts_pkg::CMD_SLEEP: begin
              if (id_ok) begin
                if (sleeping_q[in_idx] || (sleep_cnt_q >= CNTW'(MAX_THREADS))) begin
                  res_d.status = fts_pkg::STAT_DUP;
                end else begin
                  conv_start = 1'b1;
                  state_d    = fts_pkg::ST_CONV;
                end
              end
            end
            fts_pkg::CMD_SCHED: begin
              scan_i_d = '0;
              kept_d   = '0;
              woken_d  = '0;
              state_d  = fts_pkg::ST_SCAN_RD;
            end
            default: begin
              state_d = fts_pkg::ST_DONE;
            end
          endcase
        end
      end

      fts_pkg::ST_CONV: begin
        // Store the wake time and append the thread to the sleep list.
        if (conv_done) begin
          wake_we              = 1'b1;
          order_we             = 1'b1;
          sleep_cnt_d          = sleep_cnt_q + CNTW'(1);
          sleeping_d[cur_id_q] = 1'b1;
          state_d              = fts_pkg::ST_DONE;
        end
      end

      fts_pkg::ST_SCAN_RD: begin
        // The sleep-list read at scan_i is issued here; the end of the list closes the scan.
        if (scan_i_q == sleep_cnt_q) begin
          sleep_cnt_d       = kept_q;
          res_d.woken_count = fts_pkg::WOKEN_W'(woken_q);
          state_d           = fts_pkg::ST_POP_RD;
        end else begin
          state_d = fts_pkg::ST_SCAN_WK;
        end
      end

      fts_pkg::ST_SCAN_WK: begin
        // The thread id is back; its wake time is read in this cycle.
        state_d = fts_pkg::ST_SCAN_CMP;
      end

      fts_pkg::ST_SCAN_CMP: begin
        if (due) begin
          sleeping_d[order_rd_q] = 1'b0;
          woken_d                = woken_q + CNTW'(1);
          // A woken thread already on the run queue is not appended again.
          if (!on_run_q[order_rd_q] && (run_cnt_q < CNTW'(MAX_THREADS))) begin
            run_we               = 1'b1;
            run_wd               = order_rd_q;
            run_cnt_d            = run_cnt_q + CNTW'(1);
            on_run_d[order_rd_q] = 1'b1;
          end
        end else begin
          // Threads still asleep are packed toward the front in their old order.
          order_we = 1'b1;
          order_wa = IDXW'(kept_q);
          order_wd = order_rd_q;
          kept_d   = kept_q + CNTW'(1);
        end
        scan_i_d = scan_i_q + CNTW'(1);
        state_d  = fts_pkg::ST_SCAN_RD;
      end

      fts_pkg::ST_POP_RD: begin
        if (run_cnt_q == '0) begin
          res_d.status = fts_pkg::STAT_EMPTY;
          state_d      = fts_pkg::ST_DONE;
        end else begin
          state_d = fts_pkg::ST_POP;
        end
      end

      fts_pkg::ST_POP: begin
        res_d.next_thread  = fts_pkg::TID_W'(run_rd_q);
        head_d             = head_inc;
        run_cnt_d          = run_cnt_q - CNTW'(1);
        on_run_d[run_rd_q] = 1'b0;
        state_d            = fts_pkg::ST_DONE;
      end

      fts_pkg::ST_DONE: begin
        // The result moves to the output register once that register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = fts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = fts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fts_pkg::ST_IDLE;
      tps_q       <= fts_pkg::TPS_RESET;
      tick_q      <= '0;
      run_cnt_q   <= '0;
      sleep_cnt_q <= '0;
      head_q      <= '0;
      on_run_q    <= '0;
      sleeping_q  <= '0;
      scan_i_q    <= '0;
      kept_q      <= '0;
      woken_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      tick_q      <= tick_d;
      run_cnt_q   <= run_cnt_d;
      sleep_cnt_q <= sleep_cnt_d;
      head_q      <= head_d;
      on_run_q    <= on_run_d;
      sleeping_q  <= sleeping_d;
      scan_i_q    <= scan_i_d;
      kept_q      <= kept_d;
      woken_q     <= woken_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_id_q <= cur_id_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // Run queue ring: written at the tail, read at the head.
  always_ff @(posedge clk_i) begin
    if (run_we) begin
      run_mem[run_wa] <= run_wd;
    end
    run_rd_q <= run_mem[head_q];
  end

  // Sleep list: read at the scan position, written at the packing position or the end.
  always_ff @(posedge clk_i) begin
    if (order_we) begin
      order_mem[order_wa] <= order_wd;
    end
    order_rd_q <= order_mem[IDXW'(scan_i_q)];
  end

  // Wake times, indexed by thread id.
  always_ff @(posedge clk_i) begin
    if (wake_we) begin
      wake_mem[cur_id_q] <= wake_wd;
    end
    wake_rd_q <= wake_mem[order_rd_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/sv/fifo_thread_scheduler_timed_sleep_tb.sv
// Self-checking testbench for the FIFO thread scheduler with timed sleep.
`timescale 1ns / 1ps

module fifo_thread_scheduler_timed_sleep_tb;
  import fts_pkg::*;

  // Number of cycles with no item accepted on either channel before the run is
  // declared hung. The limit sits far above the slowest item, a schedule over a
  // full sleep list, and above the usual run of a 74 percent receiver stall.
  localparam int HANG_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 275;
  localparam int PHASE_COUNT  = 6;
  // Largest wake delay, in ticks, that well-formed sleeps aim for, so that
  // sleepers actually come due during the run.
  localparam int SHORT_TICKS  = 12;

  // Mirror of the scheduler state. Each accepted command is applied here and
  // the outcome it must produce is queued; each result from the block is
  // compared against the oldest queued outcome.
  class sched_scoreboard;
    logic [TPS_W-1:0]  tps;
    bit [TID_W-1:0]    run_q[$];
    bit [TID_W-1:0]    sleep_list[$];
    bit [TICK_W-1:0]   wake_at[MAX_THREADS_DEF];
    bit                queued[MAX_THREADS_DEF];
    bit                asleep[MAX_THREADS_DEF];
    bit [TICK_W-1:0]   now;
    out_item_t         expected_outcomes[$];
    int                errors;

    function new();
      tps    = TPS_RESET;
      now    = '0;
      errors = 0;
    endfunction

    function void note_command(in_item_t it);
      out_item_t          want;
      bit [TID_W-1:0]     kept[$];
      bit [TID_W-1:0]     id;
      longint unsigned    span;
      int                 woken;
      want  = '0;
      woken = 0;
      case (cmd_e'(it.command))
        CMD_TICK: begin
          now = now + 1;
        end
        CMD_RUN: begin
          if (queued[it.thread_id]) begin
            want.status = STAT_DUP;
          end else if (run_q.size() < MAX_THREADS_DEF) begin
            run_q.push_back(it.thread_id);
            queued[it.thread_id] = 1'b1;
          end
        end
        CMD_SLEEP: begin
          if (asleep[it.thread_id] || sleep_list.size() >= MAX_THREADS_DEF) begin
            want.status = STAT_DUP;
          end else begin
            // Milliseconds to ticks, never less than one tick; the wake time wraps.
            span = (64'(it.sleep_ms) * 64'(tps)) / 64'(MS_PER_SEC);
            if (span == 0) span = 1;
            wake_at[it.thread_id] = now + span[TICK_W-1:0];
            sleep_list.push_back(it.thread_id);
            asleep[it.thread_id] = 1'b1;
          end
        end
        CMD_SCHED: begin
          // Wake pass in sleep-list order. A due thread that is already on the
          // run queue leaves the sleep list and counts, but is not appended twice.
          foreach (sleep_list[i]) begin
            id = sleep_list[i];
            if (now >= wake_at[id]) begin
              asleep[id] = 1'b0;
              if (!queued[id] && run_q.size() < MAX_THREADS_DEF) begin
                run_q.push_back(id);
                queued[id] = 1'b1;
              end
              woken++;
            end else begin
              kept.push_back(id);
            end
          end
          sleep_list = kept;
          want.woken_count = WOKEN_W'(woken);
          if (run_q.size() == 0) begin
            want.status = STAT_EMPTY;
          end else begin
            want.next_thread = run_q.pop_front();
            queued[want.next_thread] = 1'b0;
          end
        end
        default: ;
      endcase
      expected_outcomes.push_back(want);
    endfunction

    function void check_outcome(out_item_t got);
      out_item_t want;
      if (expected_outcomes.size() == 0) begin
        $error("result with nothing expected: status %0d next_thread %0d woken_count %0d",
               got.status, got.next_thread, got.woken_count);
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.next_thread !== want.next_thread) begin
          $error("next_thread: expected %0d, got %0d", want.next_thread, got.next_thread);
          errors++;
        end
        if (got.woken_count !== want.woken_count) begin
          $error("woken_count: expected %0d, got %0d", want.woken_count, got.woken_count);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [TPS_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_data_o;

  sched_scoreboard    sc = new();

  // Chances, in percent, that the sender holds back an item in a given cycle
  // and that the receiver refuses a result. The main sequence changes them per
  // phase.
  int                 send_idle_pct;
  int                 recv_stall_pct;

  fifo_thread_scheduler_timed_sleep u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Builds one command item.
  function automatic in_item_t cmd_item(cmd_e c, logic [TID_W-1:0] id, logic [MS_W-1:0] ms);
    in_item_t it;
    it.command   = c;
    it.thread_id = id;
    it.sleep_ms  = ms;
    return it;
  endfunction

  // Random command mix. Ticks are frequent and most sleeps are short at the
  // current rate, so sleepers keep coming due and schedules wake several at a
  // time. A sleep of a thread that is already asleep carries a fully random
  // duration, which drives the high bits of sleep_ms without parking threads;
  // a rare long sleep does the same on a live thread.
  function automatic in_item_t random_command();
    in_item_t it;
    int       pick;
    int       ms_hi;
    pick         = $urandom_range(0, 99);
    it.thread_id = TID_W'($urandom_range(0, MAX_THREADS_DEF - 1));
    it.sleep_ms  = MS_W'($urandom);
    if (pick < 35) begin
      it.command = CMD_TICK;
    end else if (pick < 55) begin
      it.command = CMD_RUN;
    end else if (pick < 80) begin
      it.command = CMD_SLEEP;
      if (!sc.asleep[it.thread_id] && $urandom_range(0, 199) != 0) begin
        ms_hi       = (SHORT_TICKS * MS_PER_SEC) / int'(sc.tps) + 1;
        it.sleep_ms = MS_W'($urandom_range(0, ms_hi));
      end
    end else begin
      it.command = CMD_SCHED;
    end
    return it;
  endfunction

  // Offers one item, idling first at the current rate, and returns at the edge
  // where it is accepted. Valid is assigned once per step, so an item that
  // follows directly keeps valid high without a glitch.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sc.note_command(it);
  endtask

  // Waits until every expected result has come back, then lets the block go
  // quiet before the rate register changes.
  task automatic wait_drained();
    while (sc.expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One-cycle write of the ticks-per-second register.
  task automatic write_rate(input logic [TPS_W-1:0] rate);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sc.tps       = rate;
  endtask

  // Receiver: samples the result channel at each edge, then decides whether to
  // stall in the coming cycle.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sc.check_outcome(out_data_o);
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Hang detector: any accepted item on either channel restarts the count.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
          $display("fifo_thread_scheduler_timed_sleep_tb: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    int rate_plan[PHASE_COUNT];
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    in_data_i      <= '0;
    send_idle_pct   = 14;
    recv_stall_pct  = 74;

    // Rate settings per phase: both extremes, the reset value, a round value
    // and two random ones.
    rate_plan[0] = 1;
    rate_plan[1] = 10000;
    rate_plan[2] = $urandom_range(1, 10000);
    rate_plan[3] = 100;
    rate_plan[4] = $urandom_range(1, 10000);
    rate_plan[5] = 1000;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset rate of 100 ticks per second. A schedule on
    // an empty queue reports empty; repeated make-runnable and repeated sleep
    // of the same thread are flagged and ignored; a zero-length sleep still
    // takes one tick; a thread can sit on both lists, and when it wakes it
    // counts as woken without being queued a second time.
    send_item(cmd_item(CMD_SCHED, 4'd0,  20'd0));
    send_item(cmd_item(CMD_RUN,   4'd0,  20'd0));
    send_item(cmd_item(CMD_RUN,   4'd0,  20'hFFFFF));
    send_item(cmd_item(CMD_RUN,   4'd15, 20'd0));
    send_item(cmd_item(CMD_SLEEP, 4'd15, 20'd0));
    send_item(cmd_item(CMD_SLEEP, 4'd15, 20'd5));
    // Longest possible sleep: this thread stays asleep for the whole run.
    send_item(cmd_item(CMD_SLEEP, 4'd9,  20'hFFFFF));
    send_item(cmd_item(CMD_SLEEP, 4'd4,  20'd10));
    // Nothing is due yet at tick zero.
    send_item(cmd_item(CMD_SCHED, 4'd0,  20'd0));
    send_item(cmd_item(CMD_TICK,  4'd0,  20'd0));
    // Threads 15 and 4 both come due; 15 is already queued.
    send_item(cmd_item(CMD_SCHED, 4'd0,  20'd0));
    send_item(cmd_item(CMD_SCHED, 4'd0,  20'd0));
    send_item(cmd_item(CMD_SCHED, 4'd0,  20'd0));
    send_item(cmd_item(CMD_SLEEP, 4'd2,  20'd30));
    send_item(cmd_item(CMD_SLEEP, 4'd5,  20'd10));
    send_item(cmd_item(CMD_TICK,  4'd0,  20'd0));
    send_item(cmd_item(CMD_SCHED, 4'd0,  20'd0));
    send_item(cmd_item(CMD_TICK,  4'd0,  20'd0));
    send_item(cmd_item(CMD_TICK,  4'd0,  20'd0));
    send_item(cmd_item(CMD_SCHED, 4'd0,  20'd0));
    send_item(cmd_item(CMD_RUN,   4'd10, 20'd0));
    send_item(cmd_item(CMD_SCHED, 4'd7,  20'd0));
    in_valid_i <= 1'b0;

    // Random phases. The first two pair a lightly idling sender with a
    // receiver that stalls often, the next two swap the roles, and the last
    // two run with no idling at all.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      write_rate(TPS_W'(rate_plan[p]));
      case (p / 2)
        0: begin
          send_idle_pct  = 14;
          recv_stall_pct = 74;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_command());
      in_valid_i <= 1'b0;
    end

    // Let any stray result show up before the verdict.
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (sc.errors == 0 && sc.expected_outcomes.size() == 0) begin
      $display("fifo_thread_scheduler_timed_sleep_tb: clean");
    end else begin
      $display("fifo_thread_scheduler_timed_sleep_tb: errors");
    end
    $finish;
  end

endmodule
